[hw/rtl/swm_pkg.sv]
// Shared types and constants for the sliding window maximum filter.
// Holds the controller/datapath command and status structs; no dependencies.
package swm_pkg;

  // Width of the window size register and its value after reset.
  localparam int CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 5'd3;

  // Commands from the controller to the datapath. At most one is high per cycle.
  typedef struct packed {
    logic accept;     // latch the incoming beat, restart the sequence if flagged
    logic rd_head;    // read the queue head entry
    logic rd_tail;    // read the queue tail entry
    logic drop_head;  // remove the head entry (it has left the window)
    logic pop_tail;   // remove the tail entry (not greater than the sample)
    logic append;     // write the sample at the tail, advance position and fill
    logic load_out;   // move the head value into the output register
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_empty;       // queue holds no entries
    logic head_expired;  // entry just read is older than the window
    logic tail_le;       // entry just read is less than or equal to the sample
    logic result_due;    // the append in progress completes a full window
    logic out_free;      // output register can take a new result this cycle
  } swm_sts_t;

endpackage

[hw/rtl/swm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the queue storage of the window maximum filter.
module swm_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/swm_datapath.sv]
// Datapath of the window maximum filter: queue RAM, pointers, position and
// fill counters, compares and the output register. Depends on swm_pkg, swm_ram.
module swm_datapath #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]  cfg_wdata,
  input  logic [SAMPLE_WIDTH-1:0]        in_sample,
  input  logic                           in_start,
  input  swm_pkg::swm_cmd_t              cmd,
  output swm_pkg::swm_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SAMPLE_WIDTH-1:0]        out_max
);
  import swm_pkg::*;

  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int PW      = $clog2(POS_MOD);
  localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW      = $clog2(MAX_WINDOW + 1);
  localparam int CMPW    = (LW > CFG_WIDTH) ? LW : CFG_WIDTH;
  localparam int KW      = (CMPW > PW) ? CMPW : PW;
  localparam int EW      = SAMPLE_WIDTH + PW;

  logic [CFG_WIDTH-1:0]    window_r, window_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [LW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] sample_r;
  logic [SAMPLE_WIDTH-1:0] out_max_r;

  logic [CFG_WIDTH-1:0]    w_one;
  logic [CMPW-1:0]         w_ext, w_eff;
  logic [LW-1:0]           fill_inc;
  logic [PW-1:0]           pos_inc;
  logic [PW:0]             age_sum;
  logic [PW-1:0]           age;
  logic [AW-1:0]           head_inc, tail_idx, app_head, waddr, raddr;
  logic [LW-1:0]           app_len;
  logic                    full;
  logic [EW-1:0]           ent_rd;
  logic [SAMPLE_WIDTH-1:0] rd_val;
  logic [PW-1:0]           rd_pos;
  logic                    out_free;

  // Circular index arithmetic over the queue depth.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [LW-1:0] b);
    logic [LW:0] s;
    s = (LW+1)'(a) + (LW+1)'(b);
    if (s >= (LW+1)'(MAX_WINDOW)) begin
      s = s - (LW+1)'(MAX_WINDOW);
    end
    return s[AW-1:0];
  endfunction

  // A size of zero acts as one; sizes above the queue depth saturate.
  always_comb begin
    w_one = (window_r == '0) ? CFG_WIDTH'(1) : window_r;
    w_ext = CMPW'(w_one);
    w_eff = (w_ext > CMPW'(MAX_WINDOW)) ? CMPW'(MAX_WINDOW) : w_ext;
  end

  assign fill_inc = (fill_r < LW'(MAX_WINDOW)) ? fill_r + LW'(1) : fill_r;
  assign pos_inc  = (pos_r == PW'(POS_MOD - 1)) ? '0 : pos_r + PW'(1);

  assign rd_val = ent_rd[SAMPLE_WIDTH-1:0];
  assign rd_pos = ent_rd[EW-1:SAMPLE_WIDTH];

  // Age of the entry just read, modulo the position range.
  always_comb begin
    age_sum = {1'b0, pos_r} + (PW+1)'(POS_MOD) - {1'b0, rd_pos};
    if (age_sum >= (PW+1)'(POS_MOD)) begin
      age_sum = age_sum - (PW+1)'(POS_MOD);
    end
    age = age_sum[PW-1:0];
  end

  assign head_inc = wrap_add(head_r, LW'(1));
  assign tail_idx = wrap_add(head_r, len_r - LW'(1));
  assign full     = (len_r == LW'(MAX_WINDOW));
  assign app_head = full ? head_inc : head_r;
  assign app_len  = full ? len_r - LW'(1) : len_r;
  assign waddr    = wrap_add(app_head, app_len);
  assign raddr    = cmd.rd_tail ? tail_idx : head_r;
  assign out_free = !out_valid_r || out_ready;

  swm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WINDOW)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (waddr),
    .wdata ({pos_r, sample_r}),
    .re    (cmd.rd_head || cmd.rd_tail),
    .raddr (raddr),
    .rdata (ent_rd)
  );

  always_comb begin
    sts.q_empty      = (len_r == '0);
    sts.head_expired = (KW'(age) >= KW'(w_eff));
    sts.tail_le      = ($signed(rd_val) <= $signed(sample_r));
    sts.result_due   = (CMPW'(fill_inc) >= w_eff);
    sts.out_free     = out_free;
  end

  always_comb begin
    window_nxt    = cfg_we ? cfg_wdata : window_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.accept) begin
      if (in_start) begin
        pos_nxt  = '0;
        fill_nxt = '0;
        head_nxt = '0;
        len_nxt  = '0;
      end
    end else if (cmd.drop_head) begin
      head_nxt = head_inc;
      len_nxt  = len_r - LW'(1);
    end else if (cmd.pop_tail) begin
      len_nxt = len_r - LW'(1);
    end else if (cmd.append) begin
      head_nxt = app_head;
      len_nxt  = app_len + LW'(1);
      pos_nxt  = pos_inc;
      fill_nxt = fill_inc;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      pos_r       <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
    end
    if (cmd.load_out) begin
      out_max_r <= rd_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;

  a_no_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drop_head || cmd.pop_tail) |-> (len_r != '0))
    else $error("queue entry removed while the queue is empty");

  a_append_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> (len_r != '0))
    else $error("queue empty right after an append");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_start) |=> (len_r == '0 && fill_r == '0 && pos_r == '0))
    else $error("start of sequence did not clear queue and counters");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output register overwritten while a result is pending");

endmodule

[hw/rtl/swm_ctrl.sv]
// Controller of the window maximum filter: sequences head expiry, tail pops,
// append and result readout for one sample at a time. Depends on swm_pkg.
module swm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output swm_pkg::swm_cmd_t cmd,
  input  swm_pkg::swm_sts_t sts
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_APPEND,
    S_RES_RD,
    S_RES
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ready_nxt = ready_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && ready_r) begin
          cmd.accept = 1'b1;
          ready_nxt  = 1'b0;
          state_nxt  = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        if (sts.q_empty) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_HEAD_CHK;
        end
      end
      S_HEAD_CHK: begin
        if (sts.head_expired) begin
          cmd.drop_head = 1'b1;
          state_nxt     = S_HEAD_RD;
        end else begin
          state_nxt = S_TAIL_RD;
        end
      end
      S_TAIL_RD: begin
        if (sts.q_empty) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_TAIL_CHK;
        end
      end
      S_TAIL_CHK: begin
        if (sts.tail_le) begin
          cmd.pop_tail = 1'b1;
          state_nxt    = S_TAIL_RD;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.result_due) begin
          state_nxt = S_RES_RD;
        end else begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RES_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          ready_nxt    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        ready_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_ready = ready_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (state_r == S_IDLE))
    else $error("input ready outside the idle state");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.append && sts.result_due) |=> (state_r == S_RES_RD && !ready_r))
    else $error("full window did not lead to a result readout");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

endmodule

[hw/rtl/sliding_window_max.sv]
// Sliding window maximum filter, top level.
// Depends on swm_pkg, swm_ctrl, swm_datapath (and swm_ram below it).
//
// Usage: samples arrive as beats on the in_ channel (in_tdata = signed
// sample, in_tuser = start flag). A beat with in_tuser high begins a new
// sequence: queue and counters are cleared before that sample is taken in.
// Once window_size samples of the sequence have been seen, every sample
// produces one beat on the out_ channel holding the largest of the last
// window_size samples; earlier samples produce nothing. window_size is
// written through cfg_wdata with cfg_we only while the block is idle; the user
// must keep to that, as the block does not enforce it. Zero acts as one
// and values above MAX_WINDOW saturate. Timing: one sample at a time; the
// block takes a new sample only once it is through with the last one. Each
// queue entry dropped at the head or popped at the tail costs one step of a
// loop, and each step of that loop is one read of the queue RAM and one
// compare. Every sample is appended once and removed at most once.
// Reset (rst_n low, synchronous) empties the queue, clears the counters and
// sets window_size to 3. If out_tready is low, the result waits in the
// output register; the next sample is still accepted and processed, and
// the block stalls only when that sample's own result is due.
module sliding_window_max #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // sample, zero pad
  input  logic                                   in_tuser,   // start_req
  // Result channel.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] out_tdata,  // window_max, zero pad
  // Configuration: window_size register.
  input  logic                                   cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]          cfg_wdata
);
  import swm_pkg::*;

  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  swm_cmd_t                cmd;
  swm_sts_t                sts;
  logic [SAMPLE_WIDTH-1:0] max_val;

  // The controller owns the input handshake; the datapath owns the output
  // register and its handshake.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swm_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_start  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_max   (max_val)
  );

  // Pad the result up to whole bytes with zeros.
  assign out_tdata = TDW'(max_val);

endmodule
